// ----- src/tpcb_pkg.sv -----
`default_nettype none

package tpcb_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int MAX_HEIGHT = 4096;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = $clog2(MAX_HEIGHT);
   localparam int WIDTH_BITS = 12;
   localparam int HEIGHT_BITS = 13;
   localparam int COUNT_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = HEIGHT_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 12'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  width;
      logic [HEIGHT_BITS-1:0] height;
      logic                   restart;
   } cfg_type;

   typedef struct packed {
      pixel_type pixel;
      logic      emit;
      logic      last;
   } cmd_type;

   typedef enum logic {
      FR_RUN,
      FR_PAD
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SHIFT,
      BK_SUM,
      BK_OUT
   } back_state_type;

endpackage

`default_nettype wire

// ----- src/transparent_pixel_color_bleed_core.sv -----
// Fills fully transparent pixels of a raster-order RGBA frame with the truncated average
// color of their opaque neighbors, while opaque pixels pass through unchanged. A result
// trails its request by one row plus one pixel, so after the last pixel of a frame the
// user sends flush requests (req_type set) to drain the remaining results; the response
// with frame_last set ends the frame. Writing image_width or image_height restarts the
// frame. The back end serializes a line-store read and write-back for every pixel; each
// pixel request passes through the idle and shift states, and one that causes a response
// also through the sum and out states, where it waits while the response register holds
// an unaccepted response. In a frame of a single row, the first flush also steps the
// window over the one missing pixel. Reset needs no clearing pass; reset and a write of
// image_width or image_height set a block flag that holds off requests until it clears.
`default_nettype none

module transparent_pixel_color_bleed_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire tpcb_pkg::req_payload_type            req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output tpcb_pkg::rsp_payload_type                 rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tpcb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [tpcb_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   function automatic logic [tpcb_pkg::WIDTH_BITS-1:0] eff_width(
      input logic [tpcb_pkg::WIDTH_BITS-1:0] w
   );
      logic [tpcb_pkg::WIDTH_BITS-1:0] r;
      r = w;
      if (w == '0) begin
         r = tpcb_pkg::WIDTH_BITS'(1);
      end else if (w > tpcb_pkg::WIDTH_BITS'(tpcb_pkg::MAX_WIDTH)) begin
         r = tpcb_pkg::WIDTH_BITS'(tpcb_pkg::MAX_WIDTH);
      end
      return r;
   endfunction

   function automatic logic [tpcb_pkg::HEIGHT_BITS-1:0] eff_height(
      input logic [tpcb_pkg::HEIGHT_BITS-1:0] h
   );
      logic [tpcb_pkg::HEIGHT_BITS-1:0] r;
      r = h;
      if (h == '0) begin
         r = tpcb_pkg::HEIGHT_BITS'(1);
      end else if (h > tpcb_pkg::HEIGHT_BITS'(tpcb_pkg::MAX_HEIGHT)) begin
         r = tpcb_pkg::HEIGHT_BITS'(tpcb_pkg::MAX_HEIGHT);
      end
      return r;
   endfunction

   logic [tpcb_pkg::WIDTH_BITS-1:0]  width_ff;
   logic [tpcb_pkg::HEIGHT_BITS-1:0] height_ff;
   logic                             restart;
   tpcb_pkg::cfg_type                frame_cfg;
   logic                             push_valid;
   tpcb_pkg::cmd_type                push_cmd;
   logic                             queue_full;
   logic                             queue_empty;
   logic                             queue_pop;
   tpcb_pkg::cmd_type                queue_head;

   assign csr_ready = 1'b1;
   assign restart = csr_valid && (csr_index == tpcb_pkg::CSR_IMAGE_WIDTH ||
                                  csr_index == tpcb_pkg::CSR_IMAGE_HEIGHT);
   assign frame_cfg.width = width_ff;
   assign frame_cfg.height = height_ff;
   assign frame_cfg.restart = restart;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= tpcb_pkg::WIDTH_RESET;
         height_ff <= tpcb_pkg::HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            tpcb_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= eff_width(csr_data[tpcb_pkg::WIDTH_BITS-1:0]);
            end
            tpcb_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= eff_height(csr_data);
            end
            default: begin
            end
         endcase
      end
   end

   tpcb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (frame_cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   tpcb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .clear    (restart),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .head     (queue_head),
      .empty    (queue_empty)
   );

   tpcb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (frame_cfg),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ----- src/tpcb_queue.sv -----
`default_nettype none

module tpcb_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire logic              push,
   input  wire tpcb_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output tpcb_pkg::cmd_type      head,
   output logic                   empty
);

   tpcb_pkg::cmd_type entries_ff [tpcb_pkg::QUEUE_DEPTH];
   logic [tpcb_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tpcb_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tpcb_pkg::QCOUNT_BITS-1:0] count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full = (count_ff == tpcb_pkg::QCOUNT_BITS'(tpcb_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- src/tpcb_front.sv -----
`default_nettype none

module tpcb_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire tpcb_pkg::cfg_type         cfg,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire tpcb_pkg::req_payload_type req_data,
   output logic                           push_valid,
   output tpcb_pkg::cmd_type              push_cmd,
   input  wire logic                      queue_full
);

   tpcb_pkg::front_state_type state_ff, state_in;
   logic [tpcb_pkg::COUNT_BITS-1:0] taken_ff, taken_in;
   logic [tpcb_pkg::COUNT_BITS-1:0] shifts_ff, shifts_in;
   logic [tpcb_pkg::COUNT_BITS-1:0] emitted_ff, emitted_in;
   logic [tpcb_pkg::COUNT_BITS-1:0] total_ff;
   logic                            blocked_ff;
   logic [tpcb_pkg::WIDTH_BITS+tpcb_pkg::HEIGHT_BITS-1:0] area;
   logic [tpcb_pkg::COUNT_BITS-1:0] width_ext;
   logic [tpcb_pkg::COUNT_BITS-1:0] pad_target;
   logic                            is_last;

   assign area = cfg.width * cfg.height;
   assign width_ext = tpcb_pkg::COUNT_BITS'(cfg.width);
   assign pad_target = emitted_ff + width_ext + tpcb_pkg::COUNT_BITS'(1);
   assign is_last = (emitted_ff + tpcb_pkg::COUNT_BITS'(1) == total_ff);

   always_comb begin
      state_in = state_ff;
      taken_in = taken_ff;
      shifts_in = shifts_ff;
      emitted_in = emitted_ff;
      push_valid = 1'b0;
      push_cmd = '0;
      req_ready = (state_ff == tpcb_pkg::FR_RUN) && !blocked_ff && !queue_full;

      case (state_ff)
         tpcb_pkg::FR_RUN: begin
            if (req_valid && req_ready) begin
               if (req_data.req_type == tpcb_pkg::REQ_PIXEL) begin
                  if (taken_ff < total_ff) begin
                     push_valid = 1'b1;
                     push_cmd.pixel.red = req_data.in_red;
                     push_cmd.pixel.green = req_data.in_green;
                     push_cmd.pixel.blue = req_data.in_blue;
                     push_cmd.pixel.alpha = req_data.in_alpha;
                     push_cmd.emit = (taken_ff > width_ext);
                     taken_in = taken_ff + tpcb_pkg::COUNT_BITS'(1);
                     shifts_in = shifts_ff + tpcb_pkg::COUNT_BITS'(1);
                  end
               end else if (taken_ff >= total_ff) begin
                  push_valid = 1'b1;
                  push_cmd.emit = (shifts_ff == pad_target);
                  shifts_in = shifts_ff + tpcb_pkg::COUNT_BITS'(1);
                  if (!push_cmd.emit) begin
                     state_in = tpcb_pkg::FR_PAD;
                  end
               end
            end
         end
         tpcb_pkg::FR_PAD: begin
            if (!queue_full) begin
               push_valid = 1'b1;
               push_cmd.emit = (shifts_ff == pad_target);
               shifts_in = shifts_ff + tpcb_pkg::COUNT_BITS'(1);
               if (push_cmd.emit) begin
                  state_in = tpcb_pkg::FR_RUN;
               end
            end
         end
         default: begin
            state_in = tpcb_pkg::FR_RUN;
         end
      endcase

      if (push_valid && push_cmd.emit) begin
         push_cmd.last = is_last;
         emitted_in = emitted_ff + tpcb_pkg::COUNT_BITS'(1);
         if (is_last) begin
            taken_in = '0;
            shifts_in = '0;
            emitted_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         state_ff <= tpcb_pkg::FR_RUN;
         taken_ff <= '0;
         shifts_ff <= '0;
         emitted_ff <= '0;
         blocked_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         taken_ff <= taken_in;
         shifts_ff <= shifts_in;
         emitted_ff <= emitted_in;
         blocked_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= tpcb_pkg::COUNT_BITS'(area);
   end

endmodule

`default_nettype wire

// ----- src/tpcb_back.sv -----
`default_nettype none

module tpcb_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tpcb_pkg::cfg_type    cfg,
   input  wire logic                 queue_empty,
   input  wire tpcb_pkg::cmd_type    queue_head,
   output logic                      queue_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output tpcb_pkg::rsp_payload_type rsp_data
);

   localparam int SUM_BITS = 11;
   localparam int CNT_BITS = 4;
   localparam int RECIP_BITS = 16;
   localparam int RECIP_SHIFT = 15;
   localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

   function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] n);
      logic [RECIP_BITS-1:0] r;
      case (n)
         4'd1:    r = 16'd32768;
         4'd2:    r = 16'd16384;
         4'd3:    r = 16'd10923;
         4'd4:    r = 16'd8192;
         4'd5:    r = 16'd6554;
         4'd6:    r = 16'd5462;
         4'd7:    r = 16'd4682;
         4'd8:    r = 16'd4096;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   tpcb_pkg::back_state_type state_ff, state_in;
   tpcb_pkg::cmd_type        cmd_ff;
   tpcb_pkg::pixel_type      rd_upper_ff;
   tpcb_pkg::pixel_type      rd_lower_ff;
   tpcb_pkg::pixel_type      win_ff [3][3];
   tpcb_pkg::pixel_type      upper_mem [tpcb_pkg::MAX_WIDTH];
   tpcb_pkg::pixel_type      lower_mem [tpcb_pkg::MAX_WIDTH];
   logic [tpcb_pkg::COL_BITS-1:0] cq_ff, cq_in;
   logic [tpcb_pkg::COL_BITS-1:0] pc_ff, pc_in;
   logic [tpcb_pkg::ROW_BITS-1:0] pr_ff, pr_in;
   logic [SUM_BITS-1:0]      sum_red_ff, sum_green_ff, sum_blue_ff;
   logic [SUM_BITS-1:0]      sum_red, sum_green, sum_blue;
   logic [CNT_BITS-1:0]      count_ff, count;
   logic                     rsp_valid_ff;
   tpcb_pkg::rsp_payload_type rsp_data_ff;
   tpcb_pkg::pixel_type      nb [8];
   logic [7:0]               nb_ok;
   logic                     up_ok, down_ok, left_ok, right_ok;
   logic                     out_free;
   logic                     out_load;
   logic [PROD_BITS-1:0]     prod_red, prod_green, prod_blue;
   logic [RECIP_BITS-1:0]    recip_val;
   logic                     cq_wrap, pc_wrap;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign out_load = (state_ff == tpcb_pkg::BK_OUT) && out_free;
   assign queue_pop = (state_ff == tpcb_pkg::BK_IDLE) && !queue_empty;

   assign up_ok = (pr_ff != '0);
   assign down_ok = ({1'b0, pr_ff} + tpcb_pkg::HEIGHT_BITS'(1)) < cfg.height;
   assign left_ok = (pc_ff != '0);
   assign right_ok = ({1'b0, pc_ff} + tpcb_pkg::WIDTH_BITS'(1)) < cfg.width;
   assign cq_wrap = ({1'b0, cq_ff} + tpcb_pkg::WIDTH_BITS'(1)) == cfg.width;
   assign pc_wrap = ({1'b0, pc_ff} + tpcb_pkg::WIDTH_BITS'(1)) == cfg.width;

   always_comb begin
      nb[0] = win_ff[0][0];
      nb[1] = win_ff[1][0];
      nb[2] = win_ff[2][0];
      nb[3] = win_ff[0][1];
      nb[4] = win_ff[2][1];
      nb[5] = win_ff[0][2];
      nb[6] = win_ff[1][2];
      nb[7] = win_ff[2][2];
      nb_ok[0] = up_ok && left_ok;
      nb_ok[1] = up_ok;
      nb_ok[2] = up_ok && right_ok;
      nb_ok[3] = left_ok;
      nb_ok[4] = right_ok;
      nb_ok[5] = down_ok && left_ok;
      nb_ok[6] = down_ok;
      nb_ok[7] = down_ok && right_ok;
      sum_red = '0;
      sum_green = '0;
      sum_blue = '0;
      count = '0;
      for (int i = 0; i < 8; i++) begin
         if (nb_ok[i] && nb[i].alpha != 8'd0) begin
            sum_red = sum_red + SUM_BITS'(nb[i].red);
            sum_green = sum_green + SUM_BITS'(nb[i].green);
            sum_blue = sum_blue + SUM_BITS'(nb[i].blue);
            count = count + CNT_BITS'(1);
         end
      end
   end

   assign recip_val = recip(count_ff);
   assign prod_red = PROD_BITS'(sum_red_ff) * PROD_BITS'(recip_val);
   assign prod_green = PROD_BITS'(sum_green_ff) * PROD_BITS'(recip_val);
   assign prod_blue = PROD_BITS'(sum_blue_ff) * PROD_BITS'(recip_val);

   always_comb begin
      state_in = state_ff;
      cq_in = cq_ff;
      pc_in = pc_ff;
      pr_in = pr_ff;
      case (state_ff)
         tpcb_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               state_in = tpcb_pkg::BK_SHIFT;
            end
         end
         tpcb_pkg::BK_SHIFT: begin
            cq_in = cq_wrap ? '0 : cq_ff + 1'b1;
            state_in = cmd_ff.emit ? tpcb_pkg::BK_SUM : tpcb_pkg::BK_IDLE;
         end
         tpcb_pkg::BK_SUM: begin
            state_in = tpcb_pkg::BK_OUT;
         end
         tpcb_pkg::BK_OUT: begin
            if (out_free) begin
               state_in = tpcb_pkg::BK_IDLE;
               if (cmd_ff.last) begin
                  cq_in = '0;
                  pc_in = '0;
                  pr_in = '0;
               end else if (pc_wrap) begin
                  pc_in = '0;
                  pr_in = pr_ff + 1'b1;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = tpcb_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         state_ff <= tpcb_pkg::BK_IDLE;
         cq_ff <= '0;
         pc_ff <= '0;
         pr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cq_ff <= cq_in;
         pc_ff <= pc_in;
         pr_ff <= pr_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         cmd_ff <= queue_head;
         rd_upper_ff <= upper_mem[cq_ff];
         rd_lower_ff <= lower_mem[cq_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tpcb_pkg::BK_SHIFT) begin
         upper_mem[cq_ff] <= rd_lower_ff;
         lower_mem[cq_ff] <= cmd_ff.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tpcb_pkg::BK_SHIFT) begin
         for (int c = 0; c < 2; c++) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[c][r] <= win_ff[c+1][r];
            end
         end
         win_ff[2][0] <= rd_upper_ff;
         win_ff[2][1] <= rd_lower_ff;
         win_ff[2][2] <= cmd_ff.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tpcb_pkg::BK_SUM) begin
         sum_red_ff <= sum_red;
         sum_green_ff <= sum_green;
         sum_blue_ff <= sum_blue;
         count_ff <= count;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (win_ff[1][1].alpha != 8'd0) begin
            rsp_data_ff.out_red <= win_ff[1][1].red;
            rsp_data_ff.out_green <= win_ff[1][1].green;
            rsp_data_ff.out_blue <= win_ff[1][1].blue;
         end else begin
            rsp_data_ff.out_red <= prod_red[RECIP_SHIFT+7:RECIP_SHIFT];
            rsp_data_ff.out_green <= prod_green[RECIP_SHIFT+7:RECIP_SHIFT];
            rsp_data_ff.out_blue <= prod_blue[RECIP_SHIFT+7:RECIP_SHIFT];
         end
         rsp_data_ff.out_alpha <= win_ff[1][1].alpha;
         rsp_data_ff.frame_last <= cmd_ff.last;
      end
   end

endmodule

`default_nettype wire
